// ===== rtl/bounded_ordered_list_engine_macros.svh =====
// Assertion macros used by the checker.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define BOLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define BOLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bole_pkg.sv =====
`default_nettype none

package bole_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = 5;

    typedef enum logic [2:0] {
        REQ_PUSH_END   = 3'd0,
        REQ_POP_END    = 3'd1,
        REQ_PUSH_FRONT = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_INSERT     = 3'd4,
        REQ_DELETE     = 3'd5,
        REQ_REVERSE    = 3'd6
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_OOB   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type                 req_type;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  item_value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0]  removed_value;
        t_status                   status;
        logic [CNT_W-1:0]          entry_count;
        logic                      list_empty;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHR_RD,
        S_SHR_WR,
        S_PUT,
        S_DEL_RD,
        S_DEL_CAP,
        S_SHL_RD,
        S_SHL_WR,
        S_REV_RDLO,
        S_REV_RDHI,
        S_REV_WRLO,
        S_REV_WRHI,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/bole_ram.sv =====
`default_nettype none

module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/bounded_ordered_list_engine.sv =====
// Push end, insert at the count, reverse of under two entries, the unused code and any
// refused request go straight to o_done. Pop and delete capture the entry, then shift
// the ones above it down; insert below the count shifts up, then writes; reverse swaps
// pairs inward. A new transaction is taken in the o_done cycle, none while busy. Shifts
// move one entry per read and write state through the registered-read entry RAM.
// Synchronous reset clears count and sequencer, not the RAM; the receiver cannot stall.
`default_nettype none

module bounded_ordered_list_engine (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire bole_pkg::t_req i_req,
    output logic                o_done,
    output bole_pkg::t_res      o_res
);

    import bole_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_hi, n_hi;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [DATA_W-1:0] r_val, n_val;
    logic [DATA_W-1:0] r_tmp, n_tmp;
    logic [DATA_W-1:0] r_removed, n_removed;
    t_status           r_status, n_status;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              can_take;
    logic              acc;
    logic              full;
    logic              cnt_zero;
    logic              ins_oob;
    logic              del_oob;
    logic [CNT_W-1:0]  ins_pos;
    logic [CNT_W-1:0]  pop_pos;
    logic [CNT_W-1:0]  req_pos;
    logic [CNT_W-1:0]  idx_m1;
    logic [CNT_W-1:0]  idx_p1;
    logic [CNT_W-1:0]  idx_p2;

    bole_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign can_take = (r_state == S_IDLE) || (r_state == S_DONE);
    assign busy     = !can_take;
    assign acc      = start && can_take;
    assign full     = (r_cnt == CNT_W'(DEPTH));
    assign cnt_zero = (r_cnt == '0);
    assign req_pos  = CNT_W'(i_req.position);
    assign ins_oob  = (i_req.req_type == REQ_INSERT) && (req_pos > r_cnt);
    assign del_oob  = (req_pos >= r_cnt);
    assign ins_pos  = (i_req.req_type == REQ_INSERT) ? req_pos : '0;
    assign pop_pos  = (i_req.req_type == REQ_POP_END) ? (r_cnt - 1'b1) : '0;
    assign idx_m1   = r_idx - 1'b1;
    assign idx_p1   = r_idx + 1'b1;
    assign idx_p2   = r_idx + CNT_W'(2);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE, S_DONE: begin
                if (acc) begin
                    case (i_req.req_type)
                        REQ_PUSH_FRONT, REQ_INSERT: begin
                            if (ins_oob || full || (ins_pos == r_cnt)) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_SHR_RD;
                            end
                        end
                        REQ_POP_END, REQ_POP_FRONT: begin
                            n_state = cnt_zero ? S_DONE : S_DEL_RD;
                        end
                        REQ_DELETE: begin
                            n_state = del_oob ? S_DONE : S_DEL_RD;
                        end
                        REQ_REVERSE: begin
                            n_state = (r_cnt < CNT_W'(2)) ? S_DONE : S_REV_RDLO;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SHR_RD:   n_state = S_SHR_WR;
            S_SHR_WR:   n_state = (idx_m1 == r_pos) ? S_PUT : S_SHR_RD;
            S_PUT:      n_state = S_DONE;
            S_DEL_RD:   n_state = S_DEL_CAP;
            S_DEL_CAP:  n_state = (idx_p1 < r_cnt) ? S_SHL_RD : S_DONE;
            S_SHL_RD:   n_state = S_SHL_WR;
            S_SHL_WR:   n_state = (idx_p1 < r_cnt) ? S_SHL_RD : S_DONE;
            S_REV_RDLO: n_state = S_REV_RDHI;
            S_REV_RDHI: n_state = S_REV_WRLO;
            S_REV_WRLO: n_state = S_REV_WRHI;
            S_REV_WRHI: n_state = (idx_p2 < r_hi) ? S_REV_RDLO : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_hi      = r_hi;
        n_pos     = r_pos;
        n_val     = r_val;
        n_tmp     = r_tmp;
        n_removed = r_removed;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_idx[ADDR_W-1:0];
        ram_wdata = r_val;
        ram_raddr = r_idx[ADDR_W-1:0];
        unique case (r_state)
            S_IDLE, S_DONE: begin
                if (acc) begin
                    n_removed = '0;
                    n_status  = ST_OK;
                    n_val     = i_req.item_value;
                    case (i_req.req_type)
                        REQ_PUSH_END: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_cnt[ADDR_W-1:0];
                                ram_wdata = i_req.item_value;
                                n_cnt     = r_cnt + 1'b1;
                            end
                        end
                        REQ_PUSH_FRONT, REQ_INSERT: begin
                            if (ins_oob) begin
                                n_status = ST_OOB;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_cnt = r_cnt + 1'b1;
                                n_idx = r_cnt;
                                n_pos = ins_pos;
                                if (ins_pos == r_cnt) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = ins_pos[ADDR_W-1:0];
                                    ram_wdata = i_req.item_value;
                                end
                            end
                        end
                        REQ_POP_END, REQ_POP_FRONT: begin
                            if (cnt_zero) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_idx = pop_pos;
                            end
                        end
                        REQ_DELETE: begin
                            if (del_oob) begin
                                n_status = ST_OOB;
                            end else begin
                                n_idx = req_pos;
                            end
                        end
                        REQ_REVERSE: begin
                            n_idx = '0;
                            n_hi  = r_cnt - 1'b1;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SHR_RD: begin
                ram_raddr = idx_m1[ADDR_W-1:0];
            end
            S_SHR_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = idx_m1;
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[ADDR_W-1:0];
            end
            S_DEL_RD: begin
                ram_raddr = r_idx[ADDR_W-1:0];
            end
            S_DEL_CAP: begin
                n_removed = ram_rdata;
                n_cnt     = r_cnt - 1'b1;
            end
            S_SHL_RD: begin
                ram_raddr = idx_p1[ADDR_W-1:0];
            end
            S_SHL_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = idx_p1;
            end
            S_REV_RDLO: begin
                ram_raddr = r_idx[ADDR_W-1:0];
            end
            S_REV_RDHI: begin
                ram_raddr = r_hi[ADDR_W-1:0];
                n_tmp     = ram_rdata;
            end
            S_REV_WRLO: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            S_REV_WRHI: begin
                ram_we    = 1'b1;
                ram_waddr = r_hi[ADDR_W-1:0];
                ram_wdata = r_tmp;
                n_idx     = idx_p1;
                n_hi      = r_hi - 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_hi      <= n_hi;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_tmp     <= n_tmp;
        r_removed <= n_removed;
        r_status  <= n_status;
    end

    assign o_done              = (r_state == S_DONE);
    assign o_res.removed_value = $signed(r_removed);
    assign o_res.status        = r_status;
    assign o_res.entry_count   = r_cnt;
    assign o_res.list_empty    = (r_cnt == '0);

endmodule

`default_nettype wire

// ===== rtl/bole_checker.sv =====
`default_nettype none

`include "bounded_ordered_list_engine_macros.svh"

module bole_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire bole_pkg::t_req i_req,
    input wire logic           o_done,
    input wire bole_pkg::t_res o_res
);

    import bole_pkg::*;

    logic refused;
    logic unused_req;

    assign refused    = (o_res.status != ST_OK);
    assign unused_req = ^i_req;

    `BOLE_ASSERT_NXT(a_accept_progress, start && !busy && !unused_req || start && !busy && unused_req, busy || o_done, "accepted transaction neither busy nor done")
    `BOLE_ASSERT_IMP(a_empty_flag, o_done, o_res.list_empty == (o_res.entry_count == '0), "empty flag disagrees with count")
    `BOLE_ASSERT_IMP(a_count_bound, o_done, o_res.entry_count <= CNT_W'(DEPTH), "count above depth")
    `BOLE_ASSERT_IMP(a_refused_zero, o_done && refused, o_res.removed_value == '0, "refused transaction returned a value")

endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (.*);

`default_nettype wire
